FILE: rtl/core/fmts_pkg.sv
// Shared types and constants for the file type magic sniffer.
// Holds the blob snapshot type and the file class codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmts_pkg;

    // Number of leading bytes kept for signature matching.
    localparam int unsigned HEAD_LEN = 9;

    // Byte count saturation point.
    localparam logic [8:0] COUNT_MAX = 9'd256;

    // File class codes.
    localparam logic [4:0] CLS_NONE = 5'd0;
    localparam logic [4:0] CLS_PNG  = 5'd1;
    localparam logic [4:0] CLS_JPG  = 5'd2;
    localparam logic [4:0] CLS_GIF  = 5'd3;
    localparam logic [4:0] CLS_BMP  = 5'd4;
    localparam logic [4:0] CLS_ICO  = 5'd5;
    localparam logic [4:0] CLS_WEBP = 5'd6;
    localparam logic [4:0] CLS_TIFF = 5'd7;
    localparam logic [4:0] CLS_MP3  = 5'd8;
    localparam logic [4:0] CLS_OGG  = 5'd9;
    localparam logic [4:0] CLS_MP4  = 5'd10;
    localparam logic [4:0] CLS_FLAC = 5'd11;
    localparam logic [4:0] CLS_MIDI = 5'd12;
    localparam logic [4:0] CLS_JSON = 5'd13;
    localparam logic [4:0] CLS_TXT  = 5'd14;
    localparam logic [4:0] CLS_XML  = 5'd15;
    localparam logic [4:0] CLS_HTML = 5'd16;
    localparam logic [4:0] CLS_ZIP  = 5'd17;
    localparam logic [4:0] CLS_RAR  = 5'd18;
    localparam logic [4:0] CLS_7Z   = 5'd19;
    localparam logic [4:0] CLS_GZ   = 5'd20;
    localparam logic [4:0] CLS_XZ   = 5'd21;
    localparam logic [4:0] CLS_PDF  = 5'd22;
    localparam logic [4:0] CLS_DOC  = 5'd23;

    // Everything the classifier needs to know about one finished blob.
    typedef struct packed {
        logic [HEAD_LEN-1:0][7:0] head;
        logic [8:0]               count;
        logic                     printable;
    } t_blob;

endpackage

`default_nettype wire

FILE: rtl/core/fmts_accum.sv
// Byte accumulator: collects head bytes, length and the text flag per blob,
// and hands a finished blob to the classifier through a snapshot register.
// Depends on fmts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmts_accum #(
    parameter int unsigned TEXT_SCAN_LIMIT = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_byte_value,
    input  wire logic          i_last_byte,
    input  wire logic          i_snap_take,
    output logic               o_snap_valid,
    output fmts_pkg::t_blob    o_snap
);

    localparam logic [8:0] SCAN_LIMIT = 9'(TEXT_SCAN_LIMIT);

    fmts_pkg::t_blob r_acc;
    fmts_pkg::t_blob n_acc;
    fmts_pkg::t_blob r_snap;
    logic            r_snap_valid;
    logic            w_accept;
    logic            w_ctrl_byte;

    // Input stalls only while a finished blob cannot move on.
    assign o_in_stall = r_snap_valid && !i_snap_take;
    assign w_accept   = i_in_valid && !o_in_stall;

    // A control byte other than tab, LF or CR breaks the text flag.
    assign w_ctrl_byte = (i_byte_value < 8'h20) && (i_byte_value != 8'h09) &&
                         (i_byte_value != 8'h0A) && (i_byte_value != 8'h0D);

    // Blob state after taking the current byte.
    always_comb begin
        n_acc = r_acc;
        for (int i = 0; i < fmts_pkg::HEAD_LEN; i++) begin
            if (r_acc.count == 9'(i)) begin
                n_acc.head[i] = i_byte_value;
            end
        end
        if ((r_acc.count < SCAN_LIMIT) && w_ctrl_byte) begin
            n_acc.printable = 1'b0;
        end
        if (r_acc.count < fmts_pkg::COUNT_MAX) begin
            n_acc.count = r_acc.count + 9'd1;
        end
    end

    // Accumulator; it restarts after the last byte of a blob.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc.head      <= '0;
            r_acc.count     <= '0;
            r_acc.printable <= 1'b1;
        end else if (w_accept) begin
            if (i_last_byte) begin
                r_acc.head      <= '0;
                r_acc.count     <= '0;
                r_acc.printable <= 1'b1;
            end else begin
                r_acc <= n_acc;
            end
        end
    end

    // Snapshot valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (w_accept && i_last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_take) begin
            r_snap_valid <= 1'b0;
        end
    end

    // Snapshot payload.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_byte) begin
            r_snap <= n_acc;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

FILE: rtl/core/fmts_classify.sv
// Signature matcher and result register: picks the first matching file class
// for a finished blob and holds it until the consumer takes it.
// Depends on fmts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmts_classify (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_snap_valid,
    input  wire fmts_pkg::t_blob  i_snap,
    output logic                  o_snap_take,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [4:0]            o_file_class
);

    logic [4:0] r_class;
    logic [4:0] n_class;
    logic       r_out_valid;
    logic       w_out_free;
    logic [8:0] w_size;
    logic [fmts_pkg::HEAD_LEN-1:0][7:0] h;

    assign w_size = i_snap.count;
    assign h      = i_snap.head;

    // The result register can load when empty or being taken.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_snap_take = i_snap_valid && w_out_free;

    // Priority list of signatures; unreceived bytes read as zero.
    always_comb begin
        priority if (w_size < 9'd4) begin
            n_class = fmts_pkg::CLS_NONE;
        end else if (w_size >= 9'd8 && h[0] == 8'h89 && h[1] == 8'h50 &&
                     h[2] == 8'h4E && h[3] == 8'h47) begin
            n_class = fmts_pkg::CLS_PNG;
        end else if (h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF) begin
            n_class = fmts_pkg::CLS_JPG;
        end else if (w_size >= 9'd6 && h[0] == 8'h47 && h[1] == 8'h49 &&
                     h[2] == 8'h46 && h[3] == 8'h38) begin
            n_class = fmts_pkg::CLS_GIF;
        end else if (h[0] == 8'h42 && h[1] == 8'h4D) begin
            n_class = fmts_pkg::CLS_BMP;
        end else if (h[0] == 8'h00 && h[1] == 8'h00 && h[2] == 8'h01 &&
                     h[3] == 8'h00) begin
            n_class = fmts_pkg::CLS_ICO;
        end else if (h[0] == 8'h52 && h[1] == 8'h49 && h[2] == 8'h46 &&
                     h[3] == 8'h46) begin
            n_class = fmts_pkg::CLS_WEBP;
        end else if ((h[0] == 8'h49 && h[1] == 8'h49 && h[2] == 8'h2A &&
                      h[3] == 8'h00) ||
                     (h[0] == 8'h4D && h[1] == 8'h4D && h[2] == 8'h00 &&
                      h[3] == 8'h2A)) begin
            n_class = fmts_pkg::CLS_TIFF;
        end else if ((h[0] == 8'h49 && h[1] == 8'h44 && h[2] == 8'h33) ||
                     (h[0] == 8'hFF && h[1] == 8'hFB)) begin
            n_class = fmts_pkg::CLS_MP3;
        end else if (h[0] == 8'h4F && h[1] == 8'h67 && h[2] == 8'h67 &&
                     h[3] == 8'h53) begin
            n_class = fmts_pkg::CLS_OGG;
        end else if ((w_size >= 9'd12 && h[0] == 8'h00 && h[1] == 8'h00 &&
                      h[2] == 8'h00 && h[3] == 8'h1C) ||
                     (h[0] == 8'h66 && h[1] == 8'h74 && h[2] == 8'h79 &&
                      h[3] == 8'h70)) begin
            n_class = fmts_pkg::CLS_MP4;
        end else if (h[0] == 8'h46 && h[1] == 8'h4C && h[2] == 8'h41 &&
                     h[3] == 8'h43) begin
            n_class = fmts_pkg::CLS_FLAC;
        end else if (h[0] == 8'h4D && h[1] == 8'h54 && h[2] == 8'h68 &&
                     h[3] == 8'h64) begin
            n_class = fmts_pkg::CLS_MIDI;
        end else if (h[0] == 8'h7B || h[0] == 8'h5B) begin
            n_class = fmts_pkg::CLS_JSON;
        end else if ((w_size >= 9'd5 && h[0] == 8'hEF && h[1] == 8'hBB &&
                      h[2] == 8'hBF) ||
                     (h[0] == 8'hFF && h[1] == 8'hFE) ||
                     (h[0] == 8'hFE && h[1] == 8'hFF) ||
                     i_snap.printable) begin
            n_class = fmts_pkg::CLS_TXT;
        end else if ((w_size >= 9'd5 && h[0] == 8'h3C && h[1] == 8'h3F &&
                      h[2] == 8'h78 && h[3] == 8'h6D && h[4] == 8'h6C) ||
                     (h[0] == 8'h3C && h[1] == 8'h21 && h[2] == 8'h2D &&
                      h[3] == 8'h2D)) begin
            n_class = fmts_pkg::CLS_XML;
        end else if ((w_size >= 9'd9 && h[0] == 8'h3C && h[1] == 8'h21 &&
                      h[2] == 8'h44 && h[3] == 8'h4F && h[4] == 8'h43 &&
                      h[5] == 8'h54 && h[6] == 8'h59 && h[7] == 8'h50 &&
                      h[8] == 8'h45) ||
                     (w_size >= 9'd6 && h[0] == 8'h3C && h[1] == 8'h68 &&
                      h[2] == 8'h74 && h[3] == 8'h6D && h[4] == 8'h6C &&
                      h[5] == 8'h3E)) begin
            n_class = fmts_pkg::CLS_HTML;
        end else if (h[0] == 8'h50 && h[1] == 8'h4B && h[2] == 8'h03 &&
                     h[3] == 8'h04) begin
            n_class = fmts_pkg::CLS_ZIP;
        end else if (h[0] == 8'h52 && h[1] == 8'h61 && h[2] == 8'h72 &&
                     h[3] == 8'h21) begin
            n_class = fmts_pkg::CLS_RAR;
        end else if (w_size >= 9'd6 && h[0] == 8'h37 && h[1] == 8'h7A &&
                     h[2] == 8'hBC && h[3] == 8'hAF && h[4] == 8'h27 &&
                     h[5] == 8'h1C) begin
            n_class = fmts_pkg::CLS_7Z;
        end else if (h[0] == 8'h1F && h[1] == 8'h8B && h[2] == 8'h08) begin
            n_class = fmts_pkg::CLS_GZ;
        end else if (w_size >= 9'd6 && h[0] == 8'hFD && h[1] == 8'h37 &&
                     h[2] == 8'h7A && h[3] == 8'h58 && h[4] == 8'h5A &&
                     h[5] == 8'h00) begin
            n_class = fmts_pkg::CLS_XZ;
        end else if (h[0] == 8'h25 && h[1] == 8'h50 && h[2] == 8'h44 &&
                     h[3] == 8'h46) begin
            n_class = fmts_pkg::CLS_PDF;
        end else if (w_size >= 9'd8 && h[0] == 8'hD0 && h[1] == 8'hCF &&
                     h[2] == 8'h11 && h[3] == 8'hE0 && h[4] == 8'hA1 &&
                     h[5] == 8'hB1 && h[6] == 8'h1A && h[7] == 8'hE1) begin
            n_class = fmts_pkg::CLS_DOC;
        end else begin
            n_class = fmts_pkg::CLS_NONE;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= i_snap_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_class <= n_class;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_file_class = r_class;

endmodule

`default_nettype wire

FILE: rtl/core/file_type_magic_sniffer_top.sv
// Top level of the file type magic sniffer.
// Instantiates fmts_accum and fmts_classify; depends on fmts_pkg.
//
//   Channel   Valid         Stall         Payload
//   input     i_in_valid    o_in_stall    i_byte_value, i_last_byte
//   output    o_out_valid   i_out_stall   o_file_class
//
// One byte is accepted per cycle while o_in_stall is low. The class of a blob
// passes through the snapshot register and then the result register, with the
// signature matcher as combinational logic between them.
// Reset is synchronous and active low; it empties both registers and starts
// a new blob.
// The input stalls only while a result is held by i_out_stall and a second
// finished blob already waits behind it.
`timescale 1ns / 1ps
`default_nettype none

module file_type_magic_sniffer_top #(
    parameter int unsigned TEXT_SCAN_LIMIT = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [4:0]      o_file_class
);

    fmts_pkg::t_blob w_snap;
    logic            w_snap_valid;
    logic            w_snap_take;

    // Per-blob accumulation and snapshot.
    fmts_accum #(
        .TEXT_SCAN_LIMIT (TEXT_SCAN_LIMIT)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .i_snap_take  (w_snap_take),
        .o_snap_valid (w_snap_valid),
        .o_snap       (w_snap)
    );

    // Signature match and result register.
    fmts_classify u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (w_snap_valid),
        .i_snap       (w_snap),
        .o_snap_take  (w_snap_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_file_class (o_file_class)
    );

endmodule

`default_nettype wire

FILE: rtl/core/fmts_checker.sv
// Port-level checks for the file type magic sniffer, bound to the top level.
// Depends only on the ports of file_type_magic_sniffer_top.
`timescale 1ns / 1ps
`default_nettype none

module fmts_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_last_byte,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [4:0] o_file_class
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_file_class))
        else $error("stalled result changed");

    // Only defined class codes are delivered.
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_file_class <= 5'd23)
        else $error("file class out of range");

    // The input only stalls when a held result blocks the pipeline.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // A result only follows a last byte, a pending blob, or a held result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && i_last_byte && !o_in_stall) |=>
        !o_out_valid || $past(o_in_stall) == 1'b0)
        else $error("unexpected result");

endmodule

bind file_type_magic_sniffer_top fmts_checker u_fmts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_last_byte  (i_last_byte),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_file_class (o_file_class)
);

`default_nettype wire

FILE: tb/tb_file_type_magic_sniffer_top.sv
// Self-checking testbench for file_type_magic_sniffer_top: streams blobs of bytes,
// predicts each file class internally and compares every result in order.
// Depends on fmts_pkg and the RTL of the sniffer only.
`timescale 1ns / 1ps

module tb_file_type_magic_sniffer_top;

    localparam int unsigned TEXT_SCAN_LIMIT = 256;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam logic [7:0]  TAB_BYTE        = 8'h09;
    localparam logic [7:0]  LF_BYTE         = 8'h0A;
    localparam logic [7:0]  CR_BYTE         = 8'h0D;
    localparam logic [7:0]  SPACE_BYTE      = 8'h20;
    // Kinds of random blob: signatures up to SIG_KINDS-1, then text, then noise.
    localparam int unsigned SIG_KINDS       = 31;
    localparam int unsigned TEXT_KIND_LAST  = 35;
    localparam int unsigned NOISE_KIND_LAST = 39;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_last_byte  = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [4:0] o_file_class;

    // Predicted state of the blob in flight; offset 0 sits in the top byte of blob_head.
    logic [71:0] blob_head  = '0;
    logic [8:0]  blob_count = '0;
    bit          blob_text  = 1'b1;
    logic [4:0]  expected_classes[$];
    logic [7:0]  blob_bytes[$];
    logic [4:0]  want_class;

    int unsigned sender_gap_pct   = 0;
    int unsigned receiver_gap_pct = 0;
    int unsigned bytes_offered    = 0;
    int unsigned mismatch_count   = 0;
    int unsigned cycle_count      = 0;
    bit          hold_request     = 1'b0;
    bit          out_hold_on      = 1'b0;

    file_type_magic_sniffer_top #(
        .TEXT_SCAN_LIMIT(TEXT_SCAN_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_byte_value(i_byte_value),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_file_class(o_file_class)
    );

    // Free-running clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // True if the blob holds at least need bytes and its first n bytes equal sig.
    function automatic bit starts_with(int unsigned need, int unsigned n, logic [71:0] sig);
        return (int'(blob_count) >= int'(need)) && ((blob_head >> (72 - 8 * n)) == sig);
    endfunction

    // Signature priority list applied to the finished blob.
    function automatic logic [4:0] classify_blob();
        if (blob_count < 4) return fmts_pkg::CLS_NONE;
        if (starts_with(8, 4, 72'h89504E47)) return fmts_pkg::CLS_PNG;
        if (starts_with(3, 3, 72'hFFD8FF)) return fmts_pkg::CLS_JPG;
        if (starts_with(6, 4, 72'h47494638)) return fmts_pkg::CLS_GIF;
        if (starts_with(2, 2, 72'h424D)) return fmts_pkg::CLS_BMP;
        if (starts_with(4, 4, 72'h00000100)) return fmts_pkg::CLS_ICO;
        if (starts_with(4, 4, 72'h52494646)) return fmts_pkg::CLS_WEBP;
        if (starts_with(4, 4, 72'h49492A00) || starts_with(4, 4, 72'h4D4D002A))
            return fmts_pkg::CLS_TIFF;
        if (starts_with(3, 3, 72'h494433) || starts_with(4, 2, 72'hFFFB))
            return fmts_pkg::CLS_MP3;
        if (starts_with(4, 4, 72'h4F676753)) return fmts_pkg::CLS_OGG;
        if (starts_with(12, 4, 72'h0000001C) || starts_with(4, 4, 72'h66747970))
            return fmts_pkg::CLS_MP4;
        if (starts_with(4, 4, 72'h464C4143)) return fmts_pkg::CLS_FLAC;
        if (starts_with(4, 4, 72'h4D546864)) return fmts_pkg::CLS_MIDI;
        if (blob_head[71:64] == "{" || blob_head[71:64] == "[") return fmts_pkg::CLS_JSON;
        if (starts_with(5, 3, 72'hEFBBBF) || starts_with(2, 2, 72'hFFFE) ||
            starts_with(2, 2, 72'hFEFF) || blob_text) return fmts_pkg::CLS_TXT;
        if (starts_with(5, 5, "<?xml") || starts_with(4, 4, "<!--"))
            return fmts_pkg::CLS_XML;
        if (starts_with(9, 9, "<!DOCTYPE") || starts_with(6, 6, "<html>"))
            return fmts_pkg::CLS_HTML;
        if (starts_with(4, 4, 72'h504B0304)) return fmts_pkg::CLS_ZIP;
        if (starts_with(4, 4, 72'h52617221)) return fmts_pkg::CLS_RAR;
        if (starts_with(6, 6, 72'h377ABCAF271C)) return fmts_pkg::CLS_7Z;
        if (starts_with(4, 3, 72'h1F8B08)) return fmts_pkg::CLS_GZ;
        if (starts_with(6, 6, 72'hFD377A585A00)) return fmts_pkg::CLS_XZ;
        if (starts_with(4, 4, 72'h25504446)) return fmts_pkg::CLS_PDF;
        if (starts_with(8, 8, 72'hD0CF11E0A1B11AE1)) return fmts_pkg::CLS_DOC;
        return fmts_pkg::CLS_NONE;
    endfunction

    // Fold one accepted item into the predicted blob state.
    function automatic void absorb_byte(logic [7:0] b, logic last);
        int pos;
        pos = int'(blob_count);
        if (pos < 9) blob_head[8 * (8 - pos) +: 8] = b;
        if (pos < int'(TEXT_SCAN_LIMIT) && b < SPACE_BYTE &&
            b != TAB_BYTE && b != LF_BYTE && b != CR_BYTE) blob_text = 1'b0;
        if (blob_count < fmts_pkg::COUNT_MAX) blob_count++;
        if (last) begin
            expected_classes.push_back(classify_blob());
            blob_head  = '0;
            blob_count = '0;
            blob_text  = 1'b1;
        end
    endfunction

    // Signature prefix for each random blob kind, right-aligned in sig.
    function automatic void magic_for(input int unsigned kind, output logic [71:0] sig,
                                      output int unsigned len);
        case (kind)
            0:  begin sig = 72'h89504E47;       len = 4; end
            1:  begin sig = 72'hFFD8FF;         len = 3; end
            2:  begin sig = 72'h47494638;       len = 4; end
            3:  begin sig = 72'h424D;           len = 2; end
            4:  begin sig = 72'h00000100;       len = 4; end
            5:  begin sig = 72'h52494646;       len = 4; end
            6:  begin sig = 72'h49492A00;       len = 4; end
            7:  begin sig = 72'h4D4D002A;       len = 4; end
            8:  begin sig = 72'h494433;         len = 3; end
            9:  begin sig = 72'hFFFB;           len = 2; end
            10: begin sig = 72'h4F676753;       len = 4; end
            11: begin sig = 72'h0000001C;       len = 4; end
            12: begin sig = 72'h66747970;       len = 4; end
            13: begin sig = 72'h464C4143;       len = 4; end
            14: begin sig = 72'h4D546864;       len = 4; end
            15: begin sig = "{";                len = 1; end
            16: begin sig = "[";                len = 1; end
            17: begin sig = 72'hEFBBBF;         len = 3; end
            18: begin sig = 72'hFFFE;           len = 2; end
            19: begin sig = 72'hFEFF;           len = 2; end
            20: begin sig = "<?xml";            len = 5; end
            21: begin sig = "<!--";             len = 4; end
            22: begin sig = "<!DOCTYPE";        len = 9; end
            23: begin sig = "<html>";           len = 6; end
            24: begin sig = 72'h504B0304;       len = 4; end
            25: begin sig = 72'h52617221;       len = 4; end
            26: begin sig = 72'h377ABCAF271C;   len = 6; end
            27: begin sig = 72'h1F8B08;         len = 3; end
            28: begin sig = 72'hFD377A585A00;   len = 6; end
            29: begin sig = 72'h25504446;       len = 4; end
            default: begin sig = 72'hD0CF11E0A1B11AE1; len = 8; end
        endcase
    endfunction

    // A byte that keeps the text flag set, tab, LF and CR among them.
    function automatic logic [7:0] rand_text_byte();
        case ($urandom_range(9))
            0:       return TAB_BYTE;
            1:       return LF_BYTE;
            2:       return CR_BYTE;
            default: return 8'($urandom_range(32, 255));
        endcase
    endfunction

    // A control byte that clears the text flag.
    function automatic logic [7:0] rand_ctrl_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(31)); while (b == TAB_BYTE || b == LF_BYTE || b == CR_BYTE);
        return b;
    endfunction

    // Offer one item, holding it until accepted, with random gaps before it.
    task automatic offer_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_byte_value <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        absorb_byte(b, last);
        bytes_offered++;
        @(negedge i_clk);
    endtask

    // Send the bytes in blob_bytes as one blob and empty the queue.
    task automatic offer_blob();
        int unsigned i;
        for (i = 0; i < blob_bytes.size(); i++)
            offer_byte(blob_bytes[i], i == blob_bytes.size() - 1);
        blob_bytes.delete();
    endtask

    // Send a blob of n bytes given as a right-aligned constant, first byte highest.
    task automatic offer_literal_blob(input int unsigned n, input logic [71:0] v);
        int unsigned i;
        for (i = 0; i < n; i++) blob_bytes.push_back(v[8 * (n - 1 - i) +: 8]);
        offer_blob();
    endtask

    // Mostly signature-led blobs with random tails; some corrupted, cut short, text or noise.
    task automatic send_random_blob();
        logic [71:0] sig;
        int unsigned kind, sig_len, extra, tail_mode, ctrl_at, keep, i;
        kind  = $urandom_range(NOISE_KIND_LAST);
        extra = $urandom_range(1, 12);
        if (kind < SIG_KINDS) begin
            magic_for(kind, sig, sig_len);
            for (i = 0; i < sig_len; i++) blob_bytes.push_back(sig[8 * (sig_len - 1 - i) +: 8]);
            extra = $urandom_range(0, 8);
            if ($urandom_range(7) == 0) begin
                i = $urandom_range(sig_len - 1);
                blob_bytes[i] = blob_bytes[i] ^ (8'h01 << $urandom_range(7));
            end
            if ($urandom_range(7) == 0) begin
                keep = $urandom_range(1, sig_len);
                while (blob_bytes.size() > keep) void'(blob_bytes.pop_back());
                extra = 0;
            end
        end
        tail_mode = (kind < SIG_KINDS) ? $urandom_range(2) :
                    (kind <= TEXT_KIND_LAST) ? 0 : 1;
        ctrl_at = $urandom_range(extra);
        for (i = 0; i < extra; i++) begin
            if (tail_mode == 1)
                blob_bytes.push_back(8'($urandom_range(255)));
            else if (tail_mode == 2 && i == ctrl_at)
                blob_bytes.push_back(rand_ctrl_byte());
            else
                blob_bytes.push_back(rand_text_byte());
        end
        offer_blob();
    endtask

    // Short blobs, brace first, extreme byte values, RIFF and BM.
    task automatic test_directed_blobs();
        offer_literal_blob(1, 72'h00);
        offer_literal_blob(3, "{ab");
        offer_literal_blob(4, 72'h7B000000);
        offer_literal_blob(4, 72'hFFFFFFFF);
        offer_literal_blob(4, 72'h00010203);
        offer_literal_blob(4, "RIFF");
        offer_literal_blob(2, "BM");
    endtask

    // Random blobs until the given number of items has gone in.
    task automatic test_random_blobs(input int unsigned item_target);
        int unsigned start;
        start = bytes_offered;
        while (bytes_offered - start < item_target) send_random_blob();
    endtask

    // Hold the output off for a long stretch while blobs keep arriving.
    task automatic test_output_backpressure();
        // The last item is already taken, so drop valid while waiting for the hold.
        i_in_valid <= 1'b0;
        hold_request = 1'b1;
        wait (out_hold_on);
        hold_request = 1'b0;
        @(negedge i_clk);
        repeat (12) send_random_blob();
    endtask

    // Blobs past the saturation point; control bytes just inside and past the text scan.
    task automatic test_long_text_blobs();
        int unsigned i;
        for (i = 0; i < 262; i++)
            blob_bytes.push_back(i < 5 ? 8'("<?xml" >> (8 * (4 - i))) :
                                 i >= TEXT_SCAN_LIMIT ? rand_ctrl_byte() : rand_text_byte());
        offer_blob();
        for (i = 0; i < TEXT_SCAN_LIMIT + 1; i++)
            blob_bytes.push_back(i < 5 ? 8'("<?xml" >> (8 * (4 - i))) :
                                 i == TEXT_SCAN_LIMIT - 1 ? rand_ctrl_byte() : rand_text_byte());
        offer_blob();
    endtask

    // Long hold-off of the output, timed in its own process.
    always begin
        wait (hold_request);
        @(posedge i_clk);
        out_hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold_on = 1'b0;
    end

    // Output stall: random, or held during the hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= out_hold_on || ($urandom_range(99) < receiver_gap_pct);
        end
    end

    // Compare every accepted result with the oldest predicted class.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_classes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result file_class %0d with no blob pending",
                             $realtime, o_file_class);
            end else begin
                want_class = expected_classes.pop_front();
                if (o_file_class !== want_class) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: file_class expected %0d, got %0d",
                                 $realtime, want_class, o_file_class);
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender idles lightly, receiver heavily.
        sender_gap_pct   = 27;
        receiver_gap_pct = 81;
        test_directed_blobs();
        test_random_blobs(250);

        // Sender idles heavily, receiver lightly.
        sender_gap_pct   = 81;
        receiver_gap_pct = 27;
        test_random_blobs(200);

        // No idling on either side.
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
        test_output_backpressure();
        test_long_text_blobs();

        i_in_valid <= 1'b0;
        while (expected_classes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/fmts_pkg.sv
rtl/core/fmts_accum.sv
rtl/core/fmts_classify.sv
rtl/core/file_type_magic_sniffer_top.sv
rtl/core/fmts_checker.sv
tb/tb_file_type_magic_sniffer_top.sv
